>>> src/abkf_pkg.sv
// Shared types, constants and fixed-point helpers for the angle/bias Kalman filter.
// No dependencies; used by angle_bias_kalman_filter.
`default_nettype none
package abkf_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 24;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int NUM_W   = DATA_W + FRAC_W;
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = NUM_W / DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam int DT_W    = 25;
  localparam int NOISE_W = 31;
  localparam int CFG_W   = 31;
  localparam int ADDR_W  = 2;

  localparam logic [ADDR_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [ADDR_W-1:0] REG_ANGLE_NOISE   = 2'd1;
  localparam logic [ADDR_W-1:0] REG_BIAS_NOISE    = 2'd2;
  localparam logic [ADDR_W-1:0] REG_MEAS_NOISE    = 2'd3;

  localparam logic [DT_W-1:0]    RST_SAMPLE_PERIOD = 25'd167772;
  localparam logic [NOISE_W-1:0] RST_ANGLE_NOISE   = 31'd16777;
  localparam logic [NOISE_W-1:0] RST_BIAS_NOISE    = 31'd50331;
  localparam logic [NOISE_W-1:0] RST_MEAS_NOISE    = 31'd503316;

  localparam logic signed [DATA_W-1:0] ONE   = 32'sd16777216;
  localparam logic signed [DATA_W-1:0] V_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] V_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_WB, ST_DLOAD, ST_DIV, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_PRED, OP_DTBB, OP_P00, OP_K0, OP_K1, OP_ANG, OP_BIAS,
    OP_CAA, OP_CAB, OP_CBA, OP_CBB
  } op_t;

  function automatic logic signed [DATA_W-1:0] sat_add(
      input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? V_MIN : V_MAX;
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(
      input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? V_MIN : V_MAX;
    return s[DATA_W-1:0];
  endfunction

  // floor(p / 2^FRAC_W), saturated
  function automatic logic signed [DATA_W-1:0] mul_fix(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-FRAC_W-DATA_W:0] top;
    top = p[PROD_W-1:FRAC_W+DATA_W-1];
    if (!((&top) || !(|top))) return p[PROD_W-1] ? V_MIN : V_MAX;
    return p[FRAC_W+DATA_W-1:FRAC_W];
  endfunction

  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
  endfunction

endpackage
`default_nettype wire

>>> src/angle_bias_kalman_filter.sv
// Two-state (angle, gyro bias) Kalman filter top level, one shared multiplier
// and a radix-4 restoring divider under a small sequencer. Uses abkf_pkg.
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tuser: action; tdata: rate, meas
// m_*      out  tvalid/tready      tdata: angle_out, bias_out
// cfg_*    in   cfg_we             cfg_addr: register index; cfg_wdata
//
// Predict/update beat: 9 multiplies, each in ST_MUL then ST_WB, plus two
// divides, each in ST_DLOAD then ST_DIV; the divider (2 quotient bits a
// cycle) dominates. Initialize beat: ST_IDLE goes straight to ST_OUT.
// One beat at a time: s_tready is low until the result beat is taken.
// rst is synchronous and restores register defaults and the filter state.
`default_nettype none
module angle_bias_kalman_filter (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [63:0]                        s_tdata,  // [31:0] rate, [63:32] meas
  input  wire  [0:0]                         s_tuser,  // [0] action
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [63:0]                        m_tdata,  // [31:0] angle_out, [63:32] bias_out
  input  wire                                cfg_we,
  input  wire  [abkf_pkg::ADDR_W-1:0]        cfg_addr,
  input  wire  [abkf_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int DW = abkf_pkg::DATA_W;

  abkf_pkg::state_t state, state_next;
  abkf_pkg::op_t    op;

  logic [abkf_pkg::DT_W-1:0]    sample_period;
  logic [abkf_pkg::NOISE_W-1:0] angle_noise, bias_noise, meas_noise;

  logic signed [DW-1:0] angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb;
  logic signed [DW-1:0] meas_r, rb, pred, xv, p00, p01, p10, p11, s_var, innov;
  logic signed [DW-1:0] k0, k1, omk;

  logic signed [DW-1:0]                 mul_a, mul_b, mres;
  logic signed [abkf_pkg::PROD_W-1:0]   prod;
  logic signed [DW-1:0]                 dt, qa, qb, rn, p00_v;

  logic [abkf_pkg::NUM_W-1:0]  div_num, div_q, num_nx, q_nx;
  logic [DW:0]                 div_rem, rem_nx;
  logic [DW-1:0]               div_den;
  logic                        div_neg, div_zero, div_over, div_last;
  logic [abkf_pkg::DCNT_W-1:0] div_cnt;
  logic signed [DW-1:0]        div_res;

  logic in_beat;

  assign in_beat = s_tvalid && s_tready;
  assign dt = DW'(sample_period);
  assign qa = DW'(angle_noise);
  assign qb = DW'(bias_noise);
  assign rn = DW'(meas_noise);
  assign mres = abkf_pkg::mul_fix(prod);
  assign p00_v = abkf_pkg::sat_add(abkf_pkg::sat_add(cov_aa, mres), qa);
  assign m_tdata = {bias_est, angle_est};
  assign div_last = (div_cnt == abkf_pkg::DCNT_W'(abkf_pkg::DIV_STEPS - 1));

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= abkf_pkg::RST_SAMPLE_PERIOD;
      angle_noise   <= abkf_pkg::RST_ANGLE_NOISE;
      bias_noise    <= abkf_pkg::RST_BIAS_NOISE;
      meas_noise    <= abkf_pkg::RST_MEAS_NOISE;
    end else if (cfg_we) begin
      case (cfg_addr)
        abkf_pkg::REG_SAMPLE_PERIOD: sample_period <= cfg_wdata[abkf_pkg::DT_W-1:0];
        abkf_pkg::REG_ANGLE_NOISE:   angle_noise   <= cfg_wdata;
        abkf_pkg::REG_BIAS_NOISE:    bias_noise    <= cfg_wdata;
        abkf_pkg::REG_MEAS_NOISE:    meas_noise    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    case (op)
      abkf_pkg::OP_PRED: begin mul_a = rb;  mul_b = dt;     end
      abkf_pkg::OP_DTBB: begin mul_a = dt;  mul_b = cov_bb; end
      abkf_pkg::OP_P00:  begin mul_a = dt;  mul_b = xv;     end
      abkf_pkg::OP_ANG:  begin mul_a = k0;  mul_b = innov;  end
      abkf_pkg::OP_BIAS: begin mul_a = k1;  mul_b = innov;  end
      abkf_pkg::OP_CAA:  begin mul_a = omk; mul_b = p00;    end
      abkf_pkg::OP_CAB:  begin mul_a = omk; mul_b = p01;    end
      abkf_pkg::OP_CBA:  begin mul_a = k1;  mul_b = p00;    end
      abkf_pkg::OP_CBB:  begin mul_a = k1;  mul_b = p01;    end
      default:           begin mul_a = '0;  mul_b = '0;     end
    endcase
  end

  // divider: two restoring steps per cycle
  always_comb begin
    rem_nx = div_rem;
    num_nx = div_num;
    q_nx   = div_q;
    for (int i = 0; i < abkf_pkg::DIV_BITS; i++) begin
      rem_nx = {rem_nx[DW-1:0], num_nx[abkf_pkg::NUM_W-1]};
      num_nx = {num_nx[abkf_pkg::NUM_W-2:0], 1'b0};
      if (rem_nx >= {1'b0, div_den}) begin
        rem_nx = rem_nx - {1'b0, div_den};
        q_nx   = {q_nx[abkf_pkg::NUM_W-2:0], 1'b1};
      end else begin
        q_nx   = {q_nx[abkf_pkg::NUM_W-2:0], 1'b0};
      end
    end
    div_over = div_neg ? (q_nx > abkf_pkg::NUM_W'(64'h8000_0000))
                       : (q_nx > abkf_pkg::NUM_W'(64'h7FFF_FFFF));
    if (div_zero)     div_res = '0;
    else if (div_over) div_res = div_neg ? abkf_pkg::V_MIN : abkf_pkg::V_MAX;
    else if (div_neg)  div_res = DW'(-q_nx[DW-1:0]);
    else               div_res = q_nx[DW-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      abkf_pkg::ST_IDLE:  if (s_tvalid) state_next = s_tuser[0] ? abkf_pkg::ST_OUT
                                                                : abkf_pkg::ST_MUL;
      abkf_pkg::ST_MUL:   state_next = abkf_pkg::ST_WB;
      abkf_pkg::ST_WB: begin
        if (op == abkf_pkg::OP_P00)      state_next = abkf_pkg::ST_DLOAD;
        else if (op == abkf_pkg::OP_CBB) state_next = abkf_pkg::ST_OUT;
        else                             state_next = abkf_pkg::ST_MUL;
      end
      abkf_pkg::ST_DLOAD: state_next = abkf_pkg::ST_DIV;
      abkf_pkg::ST_DIV:   if (div_last) state_next = (op == abkf_pkg::OP_K0) ?
                                          abkf_pkg::ST_DLOAD : abkf_pkg::ST_MUL;
      abkf_pkg::ST_OUT:   if (m_tready) state_next = abkf_pkg::ST_IDLE;
      default:            state_next = abkf_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_tready = (state == abkf_pkg::ST_IDLE);
    m_tvalid = (state == abkf_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= abkf_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= abkf_pkg::OP_PRED;
      angle_est <= '0;
      bias_est  <= '0;
      cov_aa    <= abkf_pkg::ONE;
      cov_ab    <= '0;
      cov_ba    <= '0;
      cov_bb    <= abkf_pkg::ONE;
      div_cnt   <= '0;
    end else begin
      case (state)
        abkf_pkg::ST_IDLE: begin
          if (in_beat) begin
            op <= abkf_pkg::OP_PRED;
            if (s_tuser[0]) begin
              angle_est <= s_tdata[63:32];
              bias_est  <= '0;
              cov_aa    <= abkf_pkg::ONE;
              cov_ab    <= '0;
              cov_ba    <= '0;
              cov_bb    <= abkf_pkg::ONE;
            end
          end
        end
        abkf_pkg::ST_WB: begin
          op <= abkf_pkg::op_t'(op + 4'd1);
          case (op)
            abkf_pkg::OP_BIAS: bias_est <= abkf_pkg::sat_add(bias_est, mres);
            abkf_pkg::OP_ANG:  angle_est <= abkf_pkg::sat_add(pred, mres);
            abkf_pkg::OP_CAA:  cov_aa <= mres;
            abkf_pkg::OP_CAB:  cov_ab <= mres;
            abkf_pkg::OP_CBA:  cov_ba <= abkf_pkg::sat_sub(p10, mres);
            abkf_pkg::OP_CBB:  cov_bb <= abkf_pkg::sat_sub(p11, mres);
            default: ;
          endcase
        end
        abkf_pkg::ST_DLOAD: div_cnt <= '0;
        abkf_pkg::ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_last) op <= abkf_pkg::op_t'(op + 4'd1);
        end
        default: ;
      endcase
    end
  end

  // datapath temporaries, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat) begin
      meas_r <= s_tdata[63:32];
      rb     <= abkf_pkg::sat_sub(s_tdata[31:0], bias_est);
    end
    if (state == abkf_pkg::ST_MUL) prod <= mul_a * mul_b;
    if (state == abkf_pkg::ST_WB) begin
      case (op)
        abkf_pkg::OP_PRED: pred <= abkf_pkg::sat_add(angle_est, mres);
        abkf_pkg::OP_DTBB: begin
          xv  <= abkf_pkg::sat_sub(abkf_pkg::sat_sub(mres, cov_ab), cov_ba);
          p01 <= abkf_pkg::sat_sub(cov_ab, mres);
          p10 <= abkf_pkg::sat_sub(cov_ba, mres);
          p11 <= abkf_pkg::sat_add(cov_bb, qb);
        end
        abkf_pkg::OP_P00: begin
          p00   <= p00_v;
          s_var <= abkf_pkg::sat_add(p00_v, rn);
          innov <= abkf_pkg::sat_sub(meas_r, pred);
        end
        default: ;
      endcase
    end
    if (state == abkf_pkg::ST_DLOAD) begin
      div_num  <= {abkf_pkg::mag((op == abkf_pkg::OP_K0) ? p00 : p10),
                   abkf_pkg::FRAC_W'(0)};
      div_den  <= abkf_pkg::mag(s_var);
      div_neg  <= ((op == abkf_pkg::OP_K0) ? p00[DW-1] : p10[DW-1]) ^ s_var[DW-1];
      div_zero <= (s_var == '0);
      div_rem  <= '0;
      div_q    <= '0;
    end
    if (state == abkf_pkg::ST_DIV) begin
      div_num <= num_nx;
      div_rem <= rem_nx;
      div_q   <= q_nx;
      if (div_last) begin
        if (op == abkf_pkg::OP_K0) begin
          k0  <= div_res;
          omk <= abkf_pkg::sat_sub(abkf_pkg::ONE, div_res);
        end else begin
          k1  <= div_res;
        end
      end
    end
  end

  a_busy_no_out: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("ready and result valid together");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_tready) else $error("ready right after accepted beat");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> s_tready) else $error("not idle after result beat");
  a_div_op: assert property (@(posedge clk) disable iff (rst)
    (state == abkf_pkg::ST_DIV) |-> (op == abkf_pkg::OP_K0 || op == abkf_pkg::OP_K1))
    else $error("divider running outside a gain step");

endmodule
`default_nettype wire
